[design/dlrq_pkg.sv]
// shared types and constants for the deferred load request queue
package dlrq_pkg;

  localparam logic [3:0] TYPE_LIMIT     = 4'd9;
  localparam logic [3:0] COOLDOWN_RESET = 4'd3;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_PROCESS = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_IDLE     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_DUP      = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  ty;
    logic [31:0] asset;
    logic [31:0] target;
    logic [31:0] context_w;
    logic [7:0]  mark;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

[design/dlrq_cell.sv]
// one queue slot: holds an entry, loads from the host side or takes its neighbor's entry
module dlrq_cell (
  input  logic                clk_i,
  input  dlrq_pkg::cell_ctrl_t ctrl_i,
  input  dlrq_pkg::entry_t    wr_entry_i,
  input  dlrq_pkg::entry_t    nxt_entry_i,
  input  logic [31:0]         cmp_target_i,
  input  logic                force_i,
  output dlrq_pkg::entry_t    entry_o,
  output logic                match_o,
  output logic                elig_o
);
  import dlrq_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= wr_entry_i;
    end else if (ctrl_i.shift) begin
      entry_q <= nxt_entry_i;
    end
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.target == cmp_target_i);
  assign elig_o  = force_i | (entry_q.mark == 8'd0);

endmodule

[design/dlrq_chain.sv]
// row of queue cells with head select, duplicate search and range eligibility
module dlrq_chain #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned IW = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk_i,
  input  logic [CW-1:0]    count_i,
  input  logic [CW-1:0]    head_i,
  input  logic [CW-1:0]    lo_i,
  input  logic [CW-1:0]    hi_i,
  input  logic             wr_en_i,
  input  dlrq_pkg::entry_t wr_entry_i,
  input  logic             shift_en_i,
  input  logic             force_i,
  input  logic [31:0]      cmp_target_i,
  output dlrq_pkg::entry_t head_o,
  output logic             dup_o,
  output logic             elig_o
);
  import dlrq_pkg::*;

  entry_t                 entries [QUEUE_DEPTH];
  cell_ctrl_t             ctrl    [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] elig;
  logic [QUEUE_DEPTH-1:0] dup_vec;
  logic [QUEUE_DEPTH-1:0] range_vec;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nxt;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = entries[i];
    end else begin : g_mid
      assign nxt = entries[i+1];
    end

    assign ctrl[i].load  = wr_en_i & (count_i == CW'(i));
    assign ctrl[i].shift = shift_en_i & (CW'(i) >= head_i);

    dlrq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .wr_entry_i   (wr_entry_i),
      .nxt_entry_i  (nxt),
      .cmp_target_i (cmp_target_i),
      .force_i      (force_i),
      .entry_o      (entries[i]),
      .match_o      (match[i]),
      .elig_o       (elig[i])
    );

    assign dup_vec[i]   = match[i] & (CW'(i) < count_i);
    assign range_vec[i] = elig[i] & (CW'(i) >= lo_i) & (CW'(i) < hi_i);
  end

  assign head_o = entries[head_i[IW-1:0]];
  assign dup_o  = |dup_vec;
  assign elig_o = |range_vec;

endmodule

[design/deferred_load_request_queue.sv]
// top level: request queue control, dispatch walk and result register
// enqueue: status result registered on the transfer; one item per cycle when drained
// process: one held entry examined per cycle at the head cell, each once per pass, stalled
// while a dispatch result waits on the output; dispatch results leave at most one per cycle
// a pass with no dispatch answers with a registered idle result; reset empties the queue,
// clears cooldown, loads cooldown_reload with 3; entry storage is not cleared
module deferred_load_request_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [3:0]  item_type_i,
  input  logic [31:0] item_index_i,
  input  logic [31:0] target_handle_i,
  input  logic [31:0] context_word_i,
  input  logic [7:0]  deferred_mark_i,
  input  logic        force_all_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [1:0]  status_o,
  output logic [3:0]  out_type_o,
  output logic [31:0] out_index_o,
  output logic [31:0] out_target_o,
  output logic [31:0] out_context_o,
  output logic        last_result_o
);
  import dlrq_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] k_q;
  logic [CW-1:0] e_q;
  logic [3:0]    cooldown_q;
  logic [3:0]    reload_q;
  logic          force_q;
  logic          promote_q;

  logic          out_valid_q;
  kind_e         kind_q;
  status_e       status_q;
  logic [3:0]    type_q;
  logic [31:0]   index_q;
  logic [31:0]   target_q;
  logic [31:0]   context_q;
  logic          last_q;

  logic          slot_free;
  logic          is_walk;
  logic          in_xfer;
  logic          is_enq;
  logic          queue_full;
  status_e       enq_status;
  logic          enq_write;
  logic [3:0]    cd_dec;
  logic          promote;
  logic          disp_any;
  logic          head_disp;
  logic          step_go;
  logic          shift_en;
  logic          res_load;
  logic [CW-1:0] k_nxt;
  logic [CW-1:0] e_nxt;
  logic [CW-1:0] range_lo;
  logic [CW-1:0] range_hi;
  logic          chain_force;
  entry_t        wr_entry;
  entry_t        head;
  logic          dup_hit;
  logic          elig_any;

  assign slot_free   = ~out_valid_q | out_ready_i;
  assign is_walk     = (state_q == S_WALK);
  assign in_ready_o  = ~is_walk & slot_free;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i & in_ready_o;
  assign is_enq      = (opcode_i == OP_ENQUEUE);
  assign queue_full  = (count_q == CW'(QUEUE_DEPTH));

  assign range_lo    = is_walk ? (k_q + CW'(1)) : '0;
  assign range_hi    = is_walk ? e_q : count_q;
  assign chain_force = is_walk ? force_q : force_all_i;

  assign wr_entry.ty        = item_type_i;
  assign wr_entry.asset     = item_index_i;
  assign wr_entry.target    = target_handle_i;
  assign wr_entry.context_w = context_word_i;
  assign wr_entry.mark      = deferred_mark_i;

  always_comb begin
    if (queue_full) begin
      enq_status = ST_FULL;
    end else if (item_type_i >= TYPE_LIMIT) begin
      enq_status = ST_BAD_TYPE;
    end else if (dup_hit) begin
      enq_status = ST_DUP;
    end else begin
      enq_status = ST_OK;
    end
  end

  assign enq_write = in_xfer & is_enq & (enq_status == ST_OK);
  assign cd_dec    = (cooldown_q != 4'd0) ? (cooldown_q - 4'd1) : 4'd0;
  assign promote   = ~force_all_i & ~elig_any & (cd_dec == 4'd0);
  assign disp_any  = (count_q != '0) & (elig_any | promote);

  assign head_disp = promote_q | force_q | (head.mark == 8'd0);
  assign step_go   = is_walk & (~head_disp | slot_free);
  assign shift_en  = step_go & head_disp;
  assign res_load  = (in_xfer & (is_enq | ~disp_any)) | shift_en;
  assign k_nxt     = head_disp ? k_q : (k_q + CW'(1));
  assign e_nxt     = head_disp ? (e_q - CW'(1)) : e_q;

  dlrq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk_i        (clk_i),
    .count_i      (count_q),
    .head_i       (k_q),
    .lo_i         (range_lo),
    .hi_i         (range_hi),
    .wr_en_i      (enq_write),
    .wr_entry_i   (wr_entry),
    .shift_en_i   (shift_en),
    .force_i      (chain_force),
    .cmp_target_i (target_handle_i),
    .head_o       (head),
    .dup_o        (dup_hit),
    .elig_o       (elig_any)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      e_q         <= '0;
      cooldown_q  <= 4'd0;
      reload_q    <= COOLDOWN_RESET;
      force_q     <= 1'b0;
      promote_q   <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_STATUS;
      status_q    <= ST_OK;
      type_q      <= 4'd0;
      index_q     <= '0;
      target_q    <= '0;
      context_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        reload_q <= cfg_data_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            type_q      <= 4'd0;
            index_q     <= '0;
            target_q    <= '0;
            context_q   <= '0;
            last_q      <= 1'b1;
            if (is_enq) begin
              kind_q   <= KIND_STATUS;
              status_q <= enq_status;
              if (enq_write) begin
                count_q <= count_q + CW'(1);
              end
            end else if (disp_any) begin
              state_q     <= S_WALK;
              k_q         <= '0;
              e_q         <= count_q;
              force_q     <= force_all_i;
              promote_q   <= promote;
              cooldown_q  <= reload_q;
            end else begin
              kind_q     <= KIND_IDLE;
              status_q   <= ST_OK;
              cooldown_q <= cd_dec;
            end
          end
        end
        S_WALK: begin
          if (step_go) begin
            promote_q <= 1'b0;
            k_q       <= k_nxt;
            e_q       <= e_nxt;
            if (head_disp) begin
              kind_q      <= KIND_DISPATCH;
              status_q    <= ST_OK;
              type_q      <= head.ty;
              index_q     <= head.asset;
              target_q    <= head.target;
              context_q   <= head.context_w;
              last_q      <= ~elig_any;
            end
            if (k_nxt == e_nxt) begin
              state_q <= S_IDLE;
              count_q <= k_nxt;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign status_o      = status_q;
  assign out_type_o    = type_q;
  assign out_index_o   = index_q;
  assign out_target_o  = target_q;
  assign out_context_o = context_q;
  assign last_result_o = last_q;

endmodule
